// ----- rtl/core/hsl2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared constants, types and helpers for the HSL to RGB pipeline.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 15;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int THIRD     = (ONE + 1) / 3;
	localparam int TWO_THIRD = (2 * ONE + 1) / 3;

	// product widths
	localparam int PROD_W  = 33;
	localparam int LEVEL_W = PROD_W - FRAC_BITS;
	localparam int LO_W    = LEVEL_W + 1;
	localparam int FACT_W  = FRAC_BITS;
	localparam int SUM_W   = LEVEL_W + 2;

	// hue function segment
	localparam logic [1:0] SEG_RISE = 2'd0;
	localparam logic [1:0] SEG_TOP  = 2'd1;
	localparam logic [1:0] SEG_FALL = 2'd2;
	localparam logic [1:0] SEG_LOW  = 2'd3;

	typedef logic [DATA_W-1:0] unit_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	function automatic unit_t sat_unit(input logic [DATA_W-1:0] v);
		unit_t r;
		if (v > DATA_W'(ONE)) begin
			r = DATA_W'(ONE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic unit_t clamp_unit(input logic signed [SUM_W-1:0] v);
		unit_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > SUM_W'(ONE)) begin
			r = DATA_W'(ONE);
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/hsl2rgb_level.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_level
// Input saturation, lightness product and the two intermediate levels.
// ----------------------------------------------------------------------------
module hsl2rgb_level (
	input  logic                                  clk,
	input  hsl2rgb_pkg::stage_en_t                en,
	input  logic [hsl2rgb_pkg::DATA_W-1:0]        hue,
	input  logic [hsl2rgb_pkg::DATA_W-1:0]        saturation,
	input  logic [hsl2rgb_pkg::DATA_W-1:0]        lightness,
	output logic [hsl2rgb_pkg::DATA_W-1:0]        hue_s1,
	output logic [hsl2rgb_pkg::LEVEL_W-1:0]       hi_s2,
	output logic signed [hsl2rgb_pkg::LO_W-1:0]   lo_s2,
	output logic [hsl2rgb_pkg::LEVEL_W-1:0]       diff_s2,
	output logic                                  szero_s2,
	output logic [hsl2rgb_pkg::DATA_W-1:0]        light_s2
);
	import hsl2rgb_pkg::*;

	unit_t                    sat_h, sat_s, sat_l;
	logic                     dark;
	logic [DATA_W:0]          mult_b;
	logic [PROD_W-1:0]        prod_s1;
	unit_t                    sat_s1, light_s1;
	logic                     dark_s1;
	logic [LEVEL_W-1:0]       pq, hi_c;
	logic signed [LO_W-1:0]   lo_c;
	logic signed [LO_W:0]     diff_c;

	// stage 1: saturate and multiply
	always_comb begin
		sat_h  = sat_unit(hue);
		sat_s  = sat_unit(saturation);
		sat_l  = sat_unit(lightness);
		dark   = ({1'b0, sat_l, 1'b0} < (DATA_W+2)'(ONE));
		mult_b = dark ? ((DATA_W+1)'(ONE) + {1'b0, sat_s}) : {1'b0, sat_s};
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			hue_s1   <= sat_h;
			sat_s1   <= sat_s;
			light_s1 <= sat_l;
			dark_s1  <= dark;
			prod_s1  <= PROD_W'(sat_l) * PROD_W'(mult_b);
		end
	end

	// stage 2: hi, lo and their difference
	always_comb begin
		pq = prod_s1[PROD_W-1:FRAC_BITS];
		if (dark_s1) begin
			hi_c = pq;
		end else begin
			hi_c = LEVEL_W'(light_s1) + LEVEL_W'(sat_s1) - pq;
		end
		lo_c   = $signed({2'b00, light_s1, 1'b0}) - $signed({1'b0, hi_c});
		diff_c = $signed({2'b00, hi_c}) - $signed({lo_c[LO_W-1], lo_c});
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			hi_s2    <= hi_c;
			lo_s2    <= lo_c;
			diff_s2  <= (diff_c < 0) ? '0 : diff_c[LEVEL_W-1:0];
			szero_s2 <= (sat_s1 == '0);
			light_s2 <= light_s1;
		end
	end

endmodule

// ----- rtl/core/hsl2rgb_chan.sv -----
// ----------------------------------------------------------------------------
// hsl2rgb_chan
// Piecewise hue function for one color channel at a fixed hue offset.
// ----------------------------------------------------------------------------
module hsl2rgb_chan #(
	parameter logic signed [17:0] HUE_OFFSET = 18'sd0
) (
	input  logic                                  clk,
	input  hsl2rgb_pkg::stage_en_t                en,
	input  logic [hsl2rgb_pkg::DATA_W-1:0]        hue_s1,
	input  logic [hsl2rgb_pkg::LEVEL_W-1:0]       diff_s2,
	input  logic [hsl2rgb_pkg::LEVEL_W-1:0]       hi_s3,
	input  logic signed [hsl2rgb_pkg::LO_W-1:0]   lo_s3,
	output logic [hsl2rgb_pkg::DATA_W-1:0]        level
);
	import hsl2rgb_pkg::*;

	logic signed [17:0]      t_raw;
	logic [DATA_W-1:0]       t;
	logic [DATA_W+2:0]       t6, t2, t3;
	logic [DATA_W+2:0]       w, w6;
	logic [1:0]              seg_c;
	logic [FACT_W-1:0]       fact_c;
	logic [1:0]              seg_s2, seg_s3;
	logic [FACT_W-1:0]       fact_s2;
	logic [PROD_W-1:0]       prod;
	logic [LEVEL_W-1:0]      ramp_s3;
	logic signed [SUM_W-1:0] sum;

	// stage 2: wrap hue, pick segment and ramp factor
	always_comb begin
		t_raw = $signed({2'b00, hue_s1}) + HUE_OFFSET;
		if (t_raw < 0) begin
			t_raw = t_raw + 18'sd32768;
		end else if (t_raw > 18'(ONE)) begin
			t_raw = t_raw - 18'sd32768;
		end
		t  = t_raw[DATA_W-1:0];
		t6 = ({3'b000, t} << 2) + ({3'b000, t} << 1);
		t2 = {3'b000, t} << 1;
		t3 = ({3'b000, t} << 1) + {3'b000, t};
		w  = (DATA_W+3)'(TWO_THIRD) - {3'b000, t};
		w6 = (w << 2) + (w << 1);
		if (t6 < (DATA_W+3)'(ONE)) begin
			seg_c  = SEG_RISE;
			fact_c = t6[FACT_W-1:0];
		end else if (t2 < (DATA_W+3)'(ONE)) begin
			seg_c  = SEG_TOP;
			fact_c = '0;
		end else if (t3 < (DATA_W+3)'(2 * ONE)) begin
			seg_c  = SEG_FALL;
			fact_c = w6[FACT_W-1:0];
		end else begin
			seg_c  = SEG_LOW;
			fact_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			seg_s2  <= seg_c;
			fact_s2 <= fact_c;
		end
	end

	// stage 3: ramp product
	assign prod = PROD_W'(diff_s2) * PROD_W'(fact_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			seg_s3  <= seg_s2;
			ramp_s3 <= prod[PROD_W-1:FRAC_BITS];
		end
	end

	// level select, registered by the caller
	always_comb begin
		sum = $signed({lo_s3[LO_W-1], lo_s3}) + $signed({2'b00, ramp_s3});
		unique case (seg_s3)
			SEG_RISE, SEG_FALL: level = clamp_unit(sum);
			SEG_TOP:            level = clamp_unit($signed({2'b00, hi_s3}));
			SEG_LOW:            level = clamp_unit($signed({lo_s3[LO_W-1], lo_s3}));
			default:            level = '0;
		endcase
	end

endmodule

// ----- rtl/core/hsl_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL to RGB color conversion, unsigned 1.15 fixed point, four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  hsl      hsl_valid/hsl_ready   hue, saturation, lightness
//  rgb      rgb_valid/rgb_ready   red, green, blue
//
//  one beat per cycle while rgb_ready is high; rgb_valid is the stage 4 valid bit
//  stages: saturate and lightness multiply, hi/lo levels and hue segment,
//  per-channel ramp multiply, level select into the output register
//  each stage holds while full and blocked, empty stages take new beats
//  reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hsl_valid,
	output logic                           hsl_ready,
	input  logic [hsl2rgb_pkg::DATA_W-1:0] hue,
	input  logic [hsl2rgb_pkg::DATA_W-1:0] saturation,
	input  logic [hsl2rgb_pkg::DATA_W-1:0] lightness,
	output logic                           rgb_valid,
	input  logic                           rgb_ready,
	output logic [hsl2rgb_pkg::DATA_W-1:0] red,
	output logic [hsl2rgb_pkg::DATA_W-1:0] green,
	output logic [hsl2rgb_pkg::DATA_W-1:0] blue
);
	import hsl2rgb_pkg::*;

	logic                   valid_s1, valid_s2, valid_s3, valid_s4;
	logic                   rdy1, rdy2, rdy3, rdy4;
	stage_en_t              en;
	unit_t                  hue_s1, light_s2, light_s3;
	logic [LEVEL_W-1:0]     hi_s2, hi_s3, diff_s2;
	logic signed [LO_W-1:0] lo_s2, lo_s3;
	logic                   szero_s2, szero_s3;
	unit_t                  lvl_r, lvl_g, lvl_b;
	unit_t                  red_s4, green_s4, blue_s4;

	// stage ready chain
	always_comb begin
		rdy4  = !valid_s4 || rgb_ready;
		rdy3  = !valid_s3 || rdy4;
		rdy2  = !valid_s2 || rdy3;
		rdy1  = !valid_s1 || rdy2;
		en.s1 = rdy1;
		en.s2 = rdy2;
		en.s3 = rdy3;
		en.s4 = rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= hsl_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	hsl2rgb_level u_level (
		.clk        (clk),
		.en         (en),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.hue_s1     (hue_s1),
		.hi_s2      (hi_s2),
		.lo_s2      (lo_s2),
		.diff_s2    (diff_s2),
		.szero_s2   (szero_s2),
		.light_s2   (light_s2)
	);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			hi_s3    <= hi_s2;
			lo_s3    <= lo_s2;
			szero_s3 <= szero_s2;
			light_s3 <= light_s2;
		end
	end

	hsl2rgb_chan #(.HUE_OFFSET(18'(THIRD))) u_red (
		.clk     (clk),
		.en      (en),
		.hue_s1  (hue_s1),
		.diff_s2 (diff_s2),
		.hi_s3   (hi_s3),
		.lo_s3   (lo_s3),
		.level   (lvl_r)
	);

	hsl2rgb_chan #(.HUE_OFFSET(18'sd0)) u_green (
		.clk     (clk),
		.en      (en),
		.hue_s1  (hue_s1),
		.diff_s2 (diff_s2),
		.hi_s3   (hi_s3),
		.lo_s3   (lo_s3),
		.level   (lvl_g)
	);

	hsl2rgb_chan #(.HUE_OFFSET(-18'(THIRD))) u_blue (
		.clk     (clk),
		.en      (en),
		.hue_s1  (hue_s1),
		.diff_s2 (diff_s2),
		.hi_s3   (hi_s3),
		.lo_s3   (lo_s3),
		.level   (lvl_b)
	);

	// gray when saturation is zero
	always_ff @(posedge clk) begin
		if (en.s4) begin
			red_s4   <= szero_s3 ? light_s3 : lvl_r;
			green_s4 <= szero_s3 ? light_s3 : lvl_g;
			blue_s4  <= szero_s3 ? light_s3 : lvl_b;
		end
	end

	assign hsl_ready = rdy1;
	assign rgb_valid = valid_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

endmodule
